>>> hw/rtl/psr_pkg.sv
// Package for the clamped PI speed regulator.
// Holds the mode codes, the register indexes, the reset values and the register bank type.
// It depends on nothing. The register interface, the top, the register bank and the core import it.
package psr_pkg;

  typedef enum logic [1:0] {
    FUNC_STOP = 2'd0,
    FUNC_FWD  = 2'd1,
    FUNC_REV  = 2'd2,
    FUNC_HOLD = 2'd3
  } func_t;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SETPOINT  = 3'd0;
  localparam cfg_idx_t CFG_PROP_GAIN = 3'd1;
  localparam cfg_idx_t CFG_INTEG_GAIN = 3'd2;
  localparam cfg_idx_t CFG_ERR_LIMIT = 3'd3;
  localparam cfg_idx_t CFG_DRIVE_MIN = 3'd4;
  localparam cfg_idx_t CFG_DRIVE_MAX = 3'd5;

  localparam logic [15:0] RST_SETPOINT   = 16'd0;
  localparam logic [15:0] RST_PROP_GAIN  = 16'd66;
  localparam logic [15:0] RST_INTEG_GAIN = 16'd197;
  localparam logic [15:0] RST_ERR_LIMIT  = 16'd2500;
  localparam logic [7:0]  RST_DRIVE_MIN  = 8'd20;
  localparam logic [7:0]  RST_DRIVE_MAX  = 8'd255;

  typedef struct packed {
    logic [15:0] setpoint_period;
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] error_limit;
    logic [7:0]  drive_min;
    logic [7:0]  drive_max;
  } psr_cfg_t;

endpackage

>>> hw/rtl/psr_in_if.sv
// Input channel of the regulator: one word carries a mode and a measured period.
// It depends on nothing.
interface psr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] measured_period;

  modport source (output valid, output func, output measured_period, input ready);
  modport sink (input valid, input func, input measured_period, output ready);
endinterface

>>> hw/rtl/psr_out_if.sv
// Result channel of the regulator: one word carries the drive and the integrator level.
// It depends on nothing.
interface psr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive;
  logic [7:0] integrator_level;

  modport source (output valid, output drive, output integrator_level, input ready);
  modport sink (input valid, input drive, input integrator_level, output ready);
endinterface

>>> hw/rtl/psr_cfg_if.sv
// Register write channel of the regulator: a register index and the data to write.
// It depends on psr_pkg for the index type.
interface psr_cfg_if
  import psr_pkg::*;
;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/pi_speed_regulator_clamped_top.sv
// Top level of the clamped PI speed regulator: register bank and datapath.
// Depends on psr_pkg, the channel interfaces, psr_cfg_regs and psr_core.
//
//   channel  role   word
//   item     sink   func, measured_period
//   result   source drive, integrator_level
//   cfg      sink   index, data (always ready)
//
// Each word passes through the input register and then the result register; its result is
// offered once the word moves on from the input register, which it does as soon as the result
// register is free or being read. One word can be taken every cycle while the result is not
// stalled, as the integrator is read and rewritten as each word moves between those registers.
// A stalled result holds its register while the input register still takes one more word if empty.
// Synchronous reset empties both registers, clears the integrator and loads the defaults.
module pi_speed_regulator_clamped_top
  import psr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  psr_in_if.sink    item,
  psr_out_if.source result,
  psr_cfg_if.sink   cfg
);

  psr_cfg_t regs;

  psr_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  psr_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .regs   (regs)
  );

endmodule

>>> hw/rtl/psr_cfg_regs.sv
// Register bank of the regulator: setpoint, gains, error limit and drive window.
// It depends on psr_pkg and psr_cfg_if.
module psr_cfg_regs
  import psr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  psr_cfg_if.sink   cfg,
  output psr_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setpoint_period <= RST_SETPOINT;
      regs.prop_gain       <= RST_PROP_GAIN;
      regs.integ_gain      <= RST_INTEG_GAIN;
      regs.error_limit     <= RST_ERR_LIMIT;
      regs.drive_min       <= RST_DRIVE_MIN;
      regs.drive_max       <= RST_DRIVE_MAX;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SETPOINT:   regs.setpoint_period <= cfg.data;
        CFG_PROP_GAIN:  regs.prop_gain       <= cfg.data;
        CFG_INTEG_GAIN: regs.integ_gain      <= cfg.data;
        CFG_ERR_LIMIT:  regs.error_limit     <= cfg.data;
        CFG_DRIVE_MIN:  regs.drive_min       <= cfg.data[7:0];
        CFG_DRIVE_MAX:  regs.drive_max       <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/psr_core.sv
// Datapath of the regulator: input register, error clamp, both gain products, drive
// and integrator clamps, integrator and result register. Depends on psr_pkg and the
// channel interfaces.
module psr_core
  import psr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  psr_in_if.sink    item,
  psr_out_if.source result,
  input  psr_cfg_t  regs
);

  localparam int IW  = 8 + FRAC_BITS;
  localparam int PW  = 32 + FRAC_BITS;
  localparam int SW  = PW + 2;
  localparam int DW  = SW - FRAC_BITS;
  localparam int LSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  logic          s_valid;
  func_t         s_func;
  logic [15:0]   s_meas;
  logic          r_valid;
  logic [7:0]    r_drive;
  logic [7:0]    r_level;
  logic [IW-1:0] integrator;
  logic          advance;

  logic signed [17:0] err_raw, lim, err, neg_err;
  logic [15:0]        mag;
  logic [31:0]        pprod, iprod;
  logic [PW-1:0]      pmag, imag;
  logic [SW-1:0]      pext, iext;
  logic signed [SW-1:0] pterm, iterm, integ_ext, total, isum, lo_q, hi_q;
  logic [DW-1:0]      ipart;
  logic [7:0]         drive_reg;
  logic [IW-1:0]      integ_reg;
  logic [7:0]         drive_next;
  logic [IW-1:0]      integrator_next;

  assign advance      = s_valid && (!r_valid || result.ready);
  assign item.ready   = !s_valid || advance;
  assign result.valid = r_valid;
  assign result.drive = r_drive;
  assign result.integrator_level = r_level;

  always_comb begin
    err_raw = $signed({2'b00, s_meas}) - $signed({2'b00, regs.setpoint_period});
    lim     = $signed({2'b00, regs.error_limit});
    if (err_raw > lim) begin
      err = lim;
    end else if (err_raw < -lim) begin
      err = -lim;
    end else begin
      err = err_raw;
    end
    neg_err = -err;
    mag     = err[17] ? neg_err[15:0] : err[15:0];

    pprod = 32'(regs.prop_gain) * 32'(mag);
    iprod = 32'(regs.integ_gain) * 32'(mag);
    pmag  = (PW'(pprod) << LSH) >> RSH;
    imag  = (PW'(iprod) << LSH) >> RSH;
    pext  = {2'b00, pmag};
    iext  = {2'b00, imag};
    pterm = err[17] ? -$signed(pext) : $signed(pext);
    iterm = err[17] ? -$signed(iext) : $signed(iext);

    integ_ext = $signed({{(SW - IW){1'b0}}, integrator});
    total     = integ_ext + pterm;
    isum      = integ_ext + iterm;

    ipart = total[SW-1:FRAC_BITS];
    if (total < 0) begin
      drive_reg = regs.drive_min;
    end else if (ipart < {{(DW - 8){1'b0}}, regs.drive_min}) begin
      drive_reg = regs.drive_min;
    end else if (ipart > {{(DW - 8){1'b0}}, regs.drive_max}) begin
      drive_reg = regs.drive_max;
    end else begin
      drive_reg = ipart[7:0];
    end

    lo_q = $signed({{(SW - IW){1'b0}}, regs.drive_min, {FRAC_BITS{1'b0}}});
    hi_q = $signed({{(SW - IW){1'b0}}, regs.drive_max, {FRAC_BITS{1'b0}}});
    if (isum < lo_q) begin
      integ_reg = lo_q[IW-1:0];
    end else if (isum > hi_q) begin
      integ_reg = hi_q[IW-1:0];
    end else begin
      integ_reg = isum[IW-1:0];
    end

    case (s_func)
      FUNC_STOP: begin
        drive_next      = 8'd0;
        integrator_next = '0;
      end
      FUNC_FWD, FUNC_REV: begin
        drive_next      = drive_reg;
        integrator_next = integ_reg;
      end
      default: begin
        drive_next      = 8'd0;
        integrator_next = integrator;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid    <= 1'b0;
      r_valid    <= 1'b0;
      integrator <= '0;
    end else begin
      if (item.ready) begin
        s_valid <= item.valid;
      end
      if (advance) begin
        r_valid    <= 1'b1;
        integrator <= integrator_next;
      end else if (result.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s_func <= func_t'(item.func);
      s_meas <= item.measured_period;
    end
    if (advance) begin
      r_drive <= drive_next;
      r_level <= integrator_next[IW-1:FRAC_BITS];
    end
  end

endmodule

>>> bench/psr_drive_monitor.sv
// Watches the word, result and register channels of the clamped PI speed regulator.
// Keeps its own copy of the registers and the integrator, works out each drive word due,
// and compares it with what comes out. Depends on psr_pkg and the three channel interfaces.
module psr_drive_monitor
  import psr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  psr_in_if    item,
  psr_out_if   result,
  psr_cfg_if   cfg,
  output int   fails,
  output int   pending
);

  localparam int ACC_W  = 8 + FRAC_BITS;
  localparam int WIDE_W = 56;
  localparam int UP     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DOWN   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  typedef struct packed {
    logic [7:0] drive;
    logic [7:0] level;
  } drive_word_t;

  psr_cfg_t          regs;
  logic [ACC_W-1:0]  integ_acc;
  drive_word_t       drive_words_due[$];

  function automatic logic signed [WIDE_W-1:0] gain_product(input logic [15:0] gain,
                                                            input logic signed [17:0] err);
    logic [16:0]       mag;
    logic [WIDE_W-1:0] prod;
    mag  = (err < 0) ? 17'(-err) : 17'(err);
    prod = WIDE_W'(gain) * WIDE_W'(mag);
    if (FRAC_BITS >= 16) begin
      prod = prod << UP;
    end else begin
      prod = prod >> DOWN;
    end
    return (err < 0) ? -$signed(prod) : $signed(prod);
  endfunction

  function automatic drive_word_t regulate_step(input func_t f, input logic [15:0] meas);
    drive_word_t              w;
    logic signed [17:0]       err;
    logic signed [17:0]       lim;
    logic signed [WIDE_W-1:0] total;
    logic signed [WIDE_W-1:0] whole;
    logic signed [WIDE_W-1:0] next_acc;
    logic signed [WIDE_W-1:0] lo_d;
    logic signed [WIDE_W-1:0] hi_d;
    w = '0;
    case (f)
      FUNC_STOP: begin
        integ_acc = '0;
      end
      FUNC_FWD, FUNC_REV: begin
        lim = $signed({2'b00, regs.error_limit});
        err = $signed({2'b00, meas}) - $signed({2'b00, regs.setpoint_period});
        if (err > lim) begin
          err = lim;
        end else if (err < -lim) begin
          err = -lim;
        end
        lo_d  = WIDE_W'(regs.drive_min);
        hi_d  = WIDE_W'(regs.drive_max);
        total = $signed(WIDE_W'(integ_acc)) + gain_product(regs.prop_gain, err);
        if (total < 0) begin
          w.drive = regs.drive_min;
        end else begin
          whole = total >>> FRAC_BITS;
          if (whole < lo_d) begin
            w.drive = regs.drive_min;
          end else if (whole > hi_d) begin
            w.drive = regs.drive_max;
          end else begin
            w.drive = whole[7:0];
          end
        end
        next_acc = $signed(WIDE_W'(integ_acc)) + gain_product(regs.integ_gain, err);
        if (next_acc < (lo_d <<< FRAC_BITS)) begin
          next_acc = lo_d <<< FRAC_BITS;
        end else if (next_acc > (hi_d <<< FRAC_BITS)) begin
          next_acc = hi_d <<< FRAC_BITS;
        end
        integ_acc = next_acc[ACC_W-1:0];
      end
      default: begin
      end
    endcase
    w.level = integ_acc[ACC_W-1 -: 8];
    return w;
  endfunction

  always @(posedge clk) begin
    drive_word_t due;
    if (rst) begin
      regs.setpoint_period = RST_SETPOINT;
      regs.prop_gain       = RST_PROP_GAIN;
      regs.integ_gain      = RST_INTEG_GAIN;
      regs.error_limit     = RST_ERR_LIMIT;
      regs.drive_min       = RST_DRIVE_MIN;
      regs.drive_max       = RST_DRIVE_MAX;
      integ_acc            = '0;
      drive_words_due.delete();
      fails                = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SETPOINT:   regs.setpoint_period = cfg.data;
          CFG_PROP_GAIN:  regs.prop_gain       = cfg.data;
          CFG_INTEG_GAIN: regs.integ_gain      = cfg.data;
          CFG_ERR_LIMIT:  regs.error_limit     = cfg.data;
          CFG_DRIVE_MIN:  regs.drive_min       = cfg.data[7:0];
          CFG_DRIVE_MAX:  regs.drive_max       = cfg.data[7:0];
          default: begin
          end
        endcase
      end
      if (item.valid && item.ready) begin
        drive_words_due.push_back(regulate_step(func_t'(item.func), item.measured_period));
      end
      if (result.valid && result.ready) begin
        if (drive_words_due.size() == 0) begin
          $error("result word with none due: drive %0d, integrator_level %0d",
                 result.drive, result.integrator_level);
          fails = fails + 1;
        end else begin
          due = drive_words_due.pop_front();
          if (result.drive !== due.drive) begin
            $error("drive: expected %0d, got %0d", due.drive, result.drive);
            fails = fails + 1;
          end
          if (result.integrator_level !== due.level) begin
            $error("integrator_level: expected %0d, got %0d", due.level,
                   result.integrator_level);
            fails = fails + 1;
          end
        end
      end
    end
    pending = drive_words_due.size();
  end

endmodule

>>> bench/testbench.sv
// Top of the bench for the clamped PI speed regulator: clock, reset, register writes,
// input words and result back-pressure, and the final verdict.
// Depends on psr_pkg, the channel interfaces, the block and psr_drive_monitor.
module testbench;
  import psr_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam cfg_idx_t CFG_SPARE_LO = 3'd6;
  localparam cfg_idx_t CFG_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   src_gap_pct;
  int   sink_stall_pct;
  logic [15:0] cur_setpoint;
  logic [15:0] cur_limit;

  psr_in_if  item_ch ();
  psr_out_if result_ch ();
  psr_cfg_if cfg_ch ();

  pi_speed_regulator_clamped_top #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  psr_drive_monitor #(.FRAC_BITS(FRAC_BITS)) i_monitor (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 99) < sink_stall_pct) begin
        result_ch.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        result_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_word(input func_t f, input logic [15:0] period);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    item_ch.valid           = 1'b1;
    item_ch.func            = f;
    item_ch.measured_period = period;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Every word yields a result, so an empty queue plus the pipeline depth means idle.
  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] pick16(input int cap);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(0, cap));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_random_settings();
    logic [15:0] hi_junk;
    logic [7:0]  lo_bound;
    logic [7:0]  hi_bound;
    hi_junk      = 16'($urandom) & 16'hFF00;
    cur_setpoint = 16'($urandom);
    cur_limit    = pick16(4000);
    case ($urandom_range(0, 5))
      0: begin
        lo_bound = 8'd0;
        hi_bound = 8'd255;
      end
      1: begin
        lo_bound = 8'($urandom);
        hi_bound = 8'($urandom);
      end
      default: begin
        lo_bound = 8'($urandom_range(0, 80));
        hi_bound = 8'($urandom_range(150, 255));
      end
    endcase
    write_reg(CFG_SETPOINT, cur_setpoint);
    write_reg(CFG_PROP_GAIN, pick16(4000));
    write_reg(CFG_INTEG_GAIN, pick16(4000));
    write_reg(CFG_ERR_LIMIT, cur_limit);
    write_reg(CFG_DRIVE_MIN, hi_junk | {8'h00, lo_bound});
    write_reg(CFG_DRIVE_MAX, (16'($urandom) & 16'hFF00) | {8'h00, hi_bound});
    if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
    end
  endtask

  task automatic send_random_word();
    func_t f;
    int    span;
    int    off;
    logic [15:0] period;
    case ($urandom_range(0, 24))
      0, 1:    f = FUNC_STOP;
      2, 3, 4: f = FUNC_HOLD;
      default: f = $urandom_range(0, 1) ? FUNC_FWD : FUNC_REV;
    endcase
    if ($urandom_range(0, 9) < 6) begin
      span   = (int'(cur_limit) > 8000) ? 8000 : int'(cur_limit) + 200;
      off    = int'($urandom_range(0, 2 * span)) - span;
      period = 16'(int'(cur_setpoint) + off);
    end else begin
      period = 16'($urandom);
    end
    send_word(f, period);
  endtask

  initial begin
    rst                     = 1'b1;
    src_gap_pct             = 0;
    sink_stall_pct          = 0;
    cur_setpoint            = RST_SETPOINT;
    cur_limit               = RST_ERR_LIMIT;
    item_ch.valid           = 1'b0;
    item_ch.func            = FUNC_STOP;
    item_ch.measured_period = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_SETPOINT;
    cfg_ch.data             = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    src_gap_pct    = 25;
    sink_stall_pct = 25;

    // Reset settings: stop, clamped positive error, hold with alternating bits.
    send_word(FUNC_STOP, 16'h0000);
    send_word(FUNC_FWD, 16'hFFFF);
    send_word(FUNC_FWD, 16'hFFFF);
    send_word(FUNC_REV, 16'h8000);
    send_word(FUNC_HOLD, 16'h5555);
    send_word(FUNC_HOLD, 16'hAAAA);
    send_word(FUNC_FWD, 16'h0000);
    send_word(FUNC_STOP, 16'hFFFF);
    wait_drained();

    // Full-scale registers: the widest negative error drives the sum below zero.
    write_reg(CFG_SETPOINT, 16'hFFFF);
    write_reg(CFG_PROP_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(CFG_ERR_LIMIT, 16'hFFFF);
    write_reg(CFG_DRIVE_MIN, 16'h0000);
    write_reg(CFG_DRIVE_MAX, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'hFFFF);
    send_word(FUNC_FWD, 16'h0000);
    send_word(FUNC_REV, 16'hFFFF);
    send_word(FUNC_FWD, 16'h0000);
    send_word(FUNC_STOP, 16'h0001);
    send_word(FUNC_REV, 16'h7FFF);
    wait_drained();

    // Lower bound above the upper bound.
    write_reg(CFG_SETPOINT, 16'd1000);
    write_reg(CFG_DRIVE_MIN, 16'd200);
    write_reg(CFG_DRIVE_MAX, 16'd50);
    write_reg(CFG_PROP_GAIN, 16'd300);
    write_reg(CFG_INTEG_GAIN, 16'd20000);
    write_reg(CFG_ERR_LIMIT, 16'd3000);
    send_word(FUNC_FWD, 16'd2000);
    send_word(FUNC_FWD, 16'd2000);
    send_word(FUNC_FWD, 16'd0);
    send_word(FUNC_REV, 16'd4000);
    send_word(FUNC_HOLD, 16'd0);
    wait_drained();

    // Zero error limit and a one-point window at the top.
    write_reg(CFG_ERR_LIMIT, 16'd0);
    write_reg(CFG_DRIVE_MIN, 16'd255);
    write_reg(CFG_DRIVE_MAX, 16'd255);
    write_reg(CFG_SPARE_LO, 16'h0000);
    send_word(FUNC_FWD, 16'hFFFF);
    send_word(FUNC_REV, 16'h0000);
    send_word(FUNC_STOP, 16'h0000);
    wait_drained();

    // Zero window with full integral gain and no proportional gain.
    write_reg(CFG_DRIVE_MIN, 16'd0);
    write_reg(CFG_DRIVE_MAX, 16'd0);
    write_reg(CFG_ERR_LIMIT, 16'hFFFF);
    write_reg(CFG_SETPOINT, 16'd0);
    write_reg(CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(CFG_PROP_GAIN, 16'd0);
    send_word(FUNC_FWD, 16'hFFFF);
    send_word(FUNC_REV, 16'h0001);
    send_word(FUNC_STOP, 16'h0000);
    wait_drained();

    for (int phase = 0; phase < 7; phase++) begin
      load_random_settings();
      case (phase % 3)
        0: begin
          src_gap_pct    = 0;
          sink_stall_pct = 30;
        end
        1: begin
          src_gap_pct    = 30;
          sink_stall_pct = 0;
        end
        default: begin
          src_gap_pct    = 15;
          sink_stall_pct = 15;
        end
      endcase
      if (phase == 6) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      for (int n = 0; n < 100; n++) begin
        if (phase == 2 && n == 50) begin
          wait_drained();
        end
        send_random_word();
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/psr_pkg.sv
hw/rtl/psr_in_if.sv
hw/rtl/psr_out_if.sv
hw/rtl/psr_cfg_if.sv
hw/rtl/psr_cfg_regs.sv
hw/rtl/psr_core.sv
hw/rtl/pi_speed_regulator_clamped_top.sv
bench/psr_drive_monitor.sv
bench/testbench.sv
